/* rtl/rk4_pkg.sv */
// rk4_pkg: shared types and constants for the runge-kutta ode stepper
// no dependencies
`timescale 1ns / 1ps
package rk4_pkg;

  localparam int unsigned STEP_W = 17;
  localparam logic [STEP_W-1:0] STEP_H_RESET = 17'd655;
  localparam logic signed [31:0] X_END_RESET = 32'sd65536;

  localparam logic [0:0] CFG_STEP_H = 1'b0;
  localparam logic [0:0] CFG_X_END  = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] x_start;
    logic signed [31:0] y_start;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               last;
    logic               div_fault;
  } out_word_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = Q_MAX;
    else if (v < -66'sd2147483648) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // unit op codes
  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1
  } uop_t;

  typedef struct packed {
    logic               start;
    uop_t               op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } unit_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
    logic               fault;
  } unit_rsp_t;

endpackage

/* rtl/rk4_alu.sv */
// rk4_alu: shared fixed-point multiply and radix-2 divide unit
// depends on rk4_pkg
`timescale 1ns / 1ps
module rk4_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  rk4_pkg::unit_req_t req,
  output rk4_pkg::unit_rsp_t rsp
);
  import rk4_pkg::*;

  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MUL  = 3'b010,
    A_DIV  = 3'b100
  } astate_t;

  astate_t            state;
  logic signed [63:0] prod;
  logic [QW-1:0]      dvd;
  logic [31:0]        dvs;
  logic [32:0]        rem;
  logic [CW-1:0]      cnt;
  logic               neg;
  logic [32:0]        rem_sh;
  logic [32:0]        rem_sub;
  logic signed [65:0] shq;
  logic signed [65:0] qv;

  assign rem_sh  = {rem[31:0], dvd[QW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_comb begin
    shq = 66'(prod) >>> FRAC_BITS;
    qv  = neg ? -$signed({{(66-QW){1'b0}}, dvd}) : $signed({{(66-QW){1'b0}}, dvd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            if (req.op == UOP_MUL) begin
              prod  <= 64'(req.a) * 64'(req.b);
              state <= A_MUL;
            end else if (req.b == 32'sd0) begin
              rsp.res   <= req.a[31] ? Q_MIN : Q_MAX;
              rsp.fault <= 1'b1;
              rsp.done  <= 1'b1;
            end else begin
              neg   <= req.a[31] ^ req.b[31];
              dvd   <= QW'(req.a[31] ? 33'(-34'(req.a)) : 33'(req.a)) << FRAC_BITS;
              dvs   <= req.b[31] ? 32'(-33'(req.b)) : 32'(req.b);
              rem   <= '0;
              cnt   <= CW'(QW);
              state <= A_DIV;
            end
          end
        end
        A_MUL: begin
          // arithmetic shift floors, for both signs
          rsp.res   <= sat66(shq);
          rsp.fault <= 1'b0;
          rsp.done  <= 1'b1;
          state     <= A_IDLE;
        end
        A_DIV: begin
          if (!rem_sub[32]) begin
            rem <= rem_sub;
            dvd <= {dvd[QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dvd <= {dvd[QW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(0)) begin
            rsp.res   <= sat66(qv);
            rsp.fault <= 1'b0;
            rsp.done  <= 1'b1;
            state     <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rk4_seq.sv */
// rk4_seq: sequencer that walks the four slope evaluations through the unit
// depends on rk4_pkg and rk4_alu
`timescale 1ns / 1ps
module rk4_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic signed [31:0]             x0,
  input  logic signed [31:0]             y0,
  input  logic [rk4_pkg::STEP_W-1:0]     h,
  output logic                           busy,
  output logic                           done,
  output logic signed [31:0]             nx,
  output logic signed [31:0]             ny,
  output logic                           fault
);
  import rk4_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_XY   = 11'b00000000010,
    S_XYY  = 11'b00000000100,
    S_XX   = 11'b00000001000,
    S_XXY  = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_HK   = 11'b00001000000,
    S_NEXT = 11'b00010000000,
    S_SUM  = 11'b00100000000,
    S_WAIT = 11'b01000000000,
    S_DIV6 = 11'b10000000000
  } sstate_t;

  sstate_t            state;
  unit_req_t          req;
  unit_rsp_t          rsp;
  logic [1:0]         kidx;
  logic signed [31:0] ex, ey, num, t;
  logic signed [31:0] xm;
  logic signed [34:0] sum;
  logic [32:0]        dmag;
  logic               dneg;
  logic [17:0]        dlow;
  logic [35:0]        dlow_p;
  logic [31:0]        dhigh_p;
  logic [32:0]        q3;
  logic signed [33:0] q6;
  logic signed [31:0] hs;

  rk4_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign hs = $signed({15'd0, h});
  assign busy = (state != S_IDLE);

  // divide by six: halve, then divide by three on the parts above and below bit 16
  assign dlow    = 18'(dmag[32:16]) + 18'(dmag[15:0]);
  assign dlow_p  = 36'(dlow) * 36'(18'd174763);
  assign dhigh_p = 32'(dmag[32:16]) * 32'(15'd21845);
  assign q3      = 33'(dhigh_p) + 33'(dlow_p[35:19]);
  assign q6      = dneg ? -$signed({1'b0, q3}) : $signed({1'b0, q3});

  function automatic logic signed [31:0] half(input logic signed [31:0] v);
    return v >>> 1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req.start <= 1'b0;
      done      <= 1'b0;
    end else begin
      req.start <= 1'b0;
      done      <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            kidx  <= 2'd0;
            fault <= 1'b0;
            ex    <= x0;
            ey    <= y0;
            xm    <= sat66(66'(x0) + 66'(hs >>> 1));
            nx    <= sat66(66'(x0) + 66'(hs));
            req   <= '{start: 1'b1, op: UOP_MUL, a: x0, b: y0};
            state <= S_XY;
          end
        end
        S_XY: if (rsp.done) begin
          req   <= '{start: 1'b1, op: UOP_MUL, a: rsp.res, b: ey};
          state <= S_XYY;
        end
        S_XYY: if (rsp.done) begin
          num   <= sat66(66'(rsp.res) + 66'(ex));
          req   <= '{start: 1'b1, op: UOP_MUL, a: ex, b: ex};
          state <= S_XX;
        end
        S_XX: if (rsp.done) begin
          req   <= '{start: 1'b1, op: UOP_MUL, a: rsp.res, b: ey};
          state <= S_XXY;
        end
        S_XXY: if (rsp.done) begin
          req   <= '{start: 1'b1, op: UOP_DIV, a: num,
                     b: sat66(66'(ey) - 66'(rsp.res))};
          state <= S_DIV;
        end
        S_DIV: if (rsp.done) begin
          fault <= fault | rsp.fault;
          req   <= '{start: 1'b1, op: UOP_MUL, a: hs, b: rsp.res};
          state <= S_HK;
        end
        S_HK: if (rsp.done) begin
          t     <= rsp.res;
          state <= S_NEXT;
        end
        S_NEXT: begin
          case (kidx)
            2'd0: begin
              sum <= 35'(t);
              ex <= xm; ey <= sat66(66'(y0) + 66'(half(t)));
            end
            2'd1: begin
              sum <= sum + 35'(t) + 35'(t);
              ey <= sat66(66'(y0) + 66'(half(t)));
            end
            2'd2: begin
              sum <= sum + 35'(t) + 35'(t);
              ex <= nx; ey <= sat66(66'(y0) + 66'(t));
            end
            default: sum <= sum + 35'(t);
          endcase
          kidx <= kidx + 2'd1;
          state <= (kidx == 2'd3) ? S_SUM : S_WAIT;
        end
        S_WAIT: begin
          req   <= '{start: 1'b1, op: UOP_MUL, a: ex, b: ey};
          state <= S_XY;
        end
        S_SUM: begin
          dneg  <= sum[34];
          dmag  <= 33'((sum[34] ? -sum : sum) >>> 1);
          state <= S_DIV6;
        end
        S_DIV6: begin
          ny    <= sat66(66'(y0) + 66'(q6));
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rk4_ode_stepper.sv */
// rk4_ode_stepper: top level, state registers, handshakes and config port
// depends on rk4_pkg and rk4_seq
//
// channel | valid      | stall      | payload
// in      | in_valid   | in_stall   | in_word  (op, x_start, y_start)
// out     | out_valid  | out_stall  | out_word (status .. div_fault)
//
// a load takes effect in the state registers; a step gives its word after
// four slope evaluations, each mostly a radix-2 divide
// (one quotient bit per cycle), plus the divide by six in S_SUM and S_DIV6
// a zero denominator skips the divide loop; a finished step answers next cycle
// reset is synchronous; state returns to finished with nothing loaded
// input is stalled while an item is at work or a result waits
`timescale 1ns / 1ps
module rk4_ode_stepper #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rk4_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rk4_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rk4_pkg::*;

  logic [STEP_W-1:0]  step_h;
  logic signed [31:0] x_end;
  logic signed [31:0] cur_x, cur_y;
  logic [31:0]        point_count;
  logic               finished;
  logic               working;
  logic               go;
  logic               sbusy, sdone, sfault;
  logic signed [31:0] nx, ny;
  logic               in_acc;

  assign in_stall = working | out_valid | sbusy;
  assign in_acc = in_valid & ~in_stall;
  assign go = in_acc & (in_word.op == OP_STEP) & ~finished;

  rk4_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk(clk), .rst(rst), .go(go), .x0(cur_x), .y0(cur_y), .h(step_h),
    .busy(sbusy), .done(sdone), .nx(nx), .ny(ny), .fault(sfault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_h      <= STEP_H_RESET;
      x_end       <= X_END_RESET;
      cur_x       <= '0;
      cur_y       <= '0;
      point_count <= '0;
      finished    <= 1'b1;
      working     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_H: step_h <= cfg_data[STEP_W-1:0];
          CFG_X_END:  x_end  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc) begin
        if (in_word.op == OP_LOAD) begin
          cur_x       <= in_word.x_start;
          cur_y       <= in_word.y_start;
          point_count <= '0;
          finished    <= 1'b0;
        end else if (finished) begin
          out_word  <= '{status: 1'b1, default: '0};
          out_valid <= 1'b1;
        end else begin
          working <= 1'b1;
          if (point_count != 32'hffffffff) point_count <= point_count + 1'b1;
          out_word.status      <= 1'b0;
          out_word.point_index <= (point_count != 32'hffffffff) ?
                                  point_count + 1'b1 : point_count;
          out_word.x_value     <= cur_x;
          out_word.y_value     <= cur_y;
        end
      end
      if (sdone) begin
        working            <= 1'b0;
        cur_x              <= nx;
        cur_y              <= ny;
        out_word.last      <= (nx > x_end);
        out_word.div_fault <= sfault;
        if (nx > x_end) finished <= 1'b1;
        out_valid          <= 1'b1;
      end
    end
  end

endmodule

/* rtl/rk4_checker.sv */
// rk4_checker: port-level assertions for the ode stepper
// depends on rk4_pkg; bound to rk4_ode_stepper
`timescale 1ns / 1ps
module rk4_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input rk4_pkg::out_word_t out_word,
  input logic               out_valid,
  input logic               out_stall
);
  import rk4_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  a_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status |-> out_word.point_index == 32'd0 && !out_word.last)
    else $error("finished word carries data");

  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.status |-> out_word.point_index != 32'd0)
    else $error("point index zero");

endmodule

bind rk4_ode_stepper rk4_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
);
